// ===== sv/srsw_pkg.sv =====
// package for the selective-repeat sender window: sizes, codes, state type, helpers
package srsw_pkg;

	localparam int WINDOW  = 8;
	localparam int SEQ_W   = 4;
	localparam int SEQ_MOD = 2 * WINDOW;
	localparam int POS_W   = $clog2(WINDOW);
	localparam int CHUNK_W = 16;
	localparam int CMD_W   = 2;
	localparam int KIND_W  = 2;

	localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DATA    = 2'd3;

	localparam logic [KIND_W-1:0] KIND_NEW  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RETX = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SLIDE,
		ST_DONE,
		ST_RETX_RD,
		ST_RETX_OUT
	} state_t;

	// positions 0..span of the window
	function automatic logic [WINDOW-1:0] span_mask(input logic [SEQ_W-1:0] span);
		logic [WINDOW-1:0] m;
		m = '0;
		for (int k = 0; k < WINDOW; k++) begin
			m[k] = (SEQ_W'(k) <= span);
		end
		return m;
	endfunction

	// last chunk test; a total of zero behaves like one
	function automatic logic is_final(input logic [CHUNK_W-1:0] idx,
			input logic [CHUNK_W-1:0] total);
		return ({1'b0, idx} + {{CHUNK_W{1'b0}}, 1'b1}) >= {1'b0, total};
	endfunction

endpackage

// ===== sv/selective_repeat_sender_window.sv =====
// Selective-repeat ARQ sender window: issues new sends, slides on acks, resends on timeout.
//
// Input channel (in_valid / in_stall) carries one event beat: command and ack_seq.
// Output channel (out_valid / out_stall) carries one packet beat per send or resend,
// plus a single done beat; run_end marks the last beat caused by an event.
// cfg_wr_en / cfg_wr_data write total_packets; write it only while the block is idle.
//
// Timing: an event is taken only in the idle state; its first beat passes the sequencer
// state and the output register, and for a timeout also the slot memory read register.
// A start or an ack that slides the window emits one new send per cycle (up to 8) while
// the receiver does not stall. A timeout emits its resends one at a time: each is read
// from the slot memory that holds the chunk index per sequence number, and the next read
// waits until it is sent. A done beat is emitted last, from its own state.
//
// Reset clears the window, bitmap, counters and flags and sets total_packets to 1;
// the slot memory needs no clearing since every slot in the window is written before
// it is read. When the receiver stalls, the output register holds its beat and the
// sequencer waits; a new event may be accepted while the last beat still waits.
module selective_repeat_sender_window
	import srsw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CHUNK_W-1:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CMD_W-1:0]   command,
	input  logic [SEQ_W-1:0]   ack_seq,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [KIND_W-1:0]  kind,
	output logic [SEQ_W-1:0]   seq_num,
	output logic [CHUNK_W-1:0] chunk_index,
	output logic               final_chunk,
	output logic               relay_pick,
	output logic               run_end
);

	// control state
	state_t             state_q, state_n;
	logic [CHUNK_W-1:0] total_q;
	logic [WINDOW-1:0]  bm_q, bm_n;
	logic [SEQ_W-1:0]   ws_q, ws_n, we_q, we_n;
	logic [CHUNK_W-1:0] issued_q, issued_n;
	logic               all_sent_q, all_sent_n;
	logic               finished_q, finished_n;
	logic [POS_W-1:0]   cnt_q, cnt_n;
	logic [WINDOW-1:0]  pend_q, pend_n;

	// output register
	logic               out_valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic               fin_q, end_q;

	// slot memory and its read register
	logic [CHUNK_W-1:0] slot_mem [SEQ_MOD];
	logic [CHUNK_W-1:0] rd_chunk_s1;
	logic [SEQ_W-1:0]   rd_seq_s1;
	logic               mem_we, mem_re;
	logic [SEQ_W-1:0]   mem_waddr, mem_raddr;

	// emission to the output register
	logic               emit;
	logic [KIND_W-1:0]  e_kind;
	logic [SEQ_W-1:0]   e_seq;
	logic [CHUNK_W-1:0] e_chunk;
	logic               e_fin, e_end;

	// helpers
	logic               accept, out_free, started, new_fin;
	logic [SEQ_W-1:0]   span, off;
	logic [WINDOW-1:0]  need, bm_set, bm_sh;
	logic [POS_W-1:0]   low_pos;

	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign started     = (issued_q != '0) || all_sent_q;
	assign span        = we_q - ws_q;
	assign off         = ack_seq - ws_q;
	assign need        = span_mask(span);
	assign bm_set      = bm_q | (WINDOW'(1) << off[POS_W-1:0]);
	assign bm_sh       = bm_q >> 1;
	assign new_fin     = is_final(issued_q, total_q);
	assign mem_waddr   = issued_q[SEQ_W-1:0];

	// lowest pending position for a resend
	always_comb begin
		low_pos = '0;
		for (int k = WINDOW - 1; k >= 0; k--) begin
			if (pend_q[k]) begin
				low_pos = POS_W'(k);
			end
		end
	end

	// sequencer: next state and beats
	always_comb begin
		state_n    = state_q;
		bm_n       = bm_q;
		ws_n       = ws_q;
		we_n       = we_q;
		issued_n   = issued_q;
		all_sent_n = all_sent_q;
		finished_n = finished_q;
		cnt_n      = cnt_q;
		pend_n     = pend_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = ws_q + SEQ_W'(low_pos);
		emit       = 1'b0;
		e_kind     = KIND_NEW;
		e_seq      = issued_q[SEQ_W-1:0];
		e_chunk    = issued_q;
		e_fin      = new_fin;
		e_end      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && !finished_q) begin
					case (command)
						CMD_START: begin
							if (!started) begin
								state_n = ST_START;
								cnt_n   = '0;
							end
						end
						CMD_ACK: begin
							if (started) begin
								if (off == '0) begin
									if (all_sent_q) begin
										bm_n = bm_q | WINDOW'(1);
										if (((bm_q | WINDOW'(1)) & need) == need) begin
											finished_n = 1'b1;
											state_n    = ST_DONE;
										end
									end else begin
										state_n = ST_SLIDE;
										cnt_n   = '0;
									end
								end else if (off <= span) begin
									bm_n = bm_set;
									if ((bm_set & need) == need) begin
										finished_n = 1'b1;
										state_n    = ST_DONE;
									end
								end
							end
						end
						CMD_TIMEOUT: begin
							if (started) begin
								pend_n  = need & ~bm_q;
								state_n = ST_RETX_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_START: begin
				if (out_free) begin
					emit       = 1'b1;
					mem_we     = 1'b1;
					we_n       = SEQ_W'(cnt_q);
					issued_n   = issued_q + CHUNK_W'(1);
					all_sent_n = new_fin;
					e_end      = new_fin || (cnt_q == POS_W'(WINDOW - 1));
					if (e_end) begin
						state_n = ST_IDLE;
					end else begin
						cnt_n = cnt_q + POS_W'(1);
					end
				end
			end
			ST_SLIDE: begin
				if (out_free) begin
					emit       = 1'b1;
					mem_we     = 1'b1;
					ws_n       = ws_q + SEQ_W'(1);
					we_n       = we_q + SEQ_W'(1);
					issued_n   = issued_q + CHUNK_W'(1);
					all_sent_n = new_fin;
					bm_n       = bm_sh;
					if (new_fin || !bm_sh[0] || (cnt_q == POS_W'(WINDOW - 1))) begin
						if ((bm_sh & need) == need) begin
							finished_n = 1'b1;
							state_n    = ST_DONE;
						end else begin
							e_end   = 1'b1;
							state_n = ST_IDLE;
						end
					end else begin
						cnt_n = cnt_q + POS_W'(1);
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_DONE;
					e_seq   = '0;
					e_chunk = '0;
					e_fin   = 1'b0;
					e_end   = 1'b1;
					state_n = ST_IDLE;
				end
			end
			ST_RETX_RD: begin
				if (pend_q == '0) begin
					state_n = ST_IDLE;
				end else begin
					mem_re  = 1'b1;
					pend_n  = pend_q & ~(WINDOW'(1) << low_pos);
					state_n = ST_RETX_OUT;
				end
			end
			ST_RETX_OUT: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_RETX;
					e_seq   = rd_seq_s1;
					e_chunk = rd_chunk_s1;
					e_fin   = is_final(rd_chunk_s1, total_q);
					e_end   = (pend_q == '0);
					state_n = e_end ? ST_IDLE : ST_RETX_RD;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= CHUNK_W'(1);
			bm_q        <= '0;
			ws_q        <= '0;
			we_q        <= '0;
			issued_q    <= '0;
			all_sent_q  <= 1'b0;
			finished_q  <= 1'b0;
			cnt_q       <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_n;
			bm_q       <= bm_n;
			ws_q       <= ws_n;
			we_q       <= we_n;
			issued_q   <= issued_n;
			all_sent_q <= all_sent_n;
			finished_q <= finished_n;
			cnt_q      <= cnt_n;
			pend_q     <= pend_n;
			if (cfg_wr_en) begin
				total_q <= cfg_wr_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= e_kind;
			seq_q   <= e_seq;
			chunk_q <= e_chunk;
			fin_q   <= e_fin;
			end_q   <= e_end;
		end
	end

	// slot memory: chunk index per sequence number
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= issued_q;
		end
		if (mem_re) begin
			rd_chunk_s1 <= slot_mem[mem_raddr];
			rd_seq_s1   <= mem_raddr;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign seq_num     = seq_q;
	assign chunk_index = chunk_q;
	assign final_chunk = fin_q;
	assign relay_pick  = chunk_q[0];
	assign run_end     = end_q;

endmodule

// ===== test/selective_repeat_sender_window_test.sv =====
// self-checking testbench for the selective-repeat sender window
module selective_repeat_sender_window_test;
	import srsw_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 6;

	// sender window as predicted from the event stream
	typedef struct packed {
		logic [CHUNK_W-1:0]                total_pk;
		logic [WINDOW-1:0]                 acked;
		logic [SEQ_W-1:0]                  base;
		logic [SEQ_W-1:0]                  top;
		logic [CHUNK_W-1:0]                issued;
		logic                              all_sent;
		logic                              finished;
		logic [SEQ_MOD-1:0][CHUNK_W-1:0]   slot;
	} window_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [SEQ_W-1:0]   seq;
		logic [CHUNK_W-1:0] chunk;
		logic               fin;
		logic               relay;
		logic               last;
	} beat_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [SEQ_W-1:0] ack;
	} event_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [CHUNK_W-1:0] cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic [CMD_W-1:0]   command = '0;
	logic [SEQ_W-1:0]   ack_seq = '0;
	logic               out_stall = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic [KIND_W-1:0]  kind;
	logic [SEQ_W-1:0]   seq_num;
	logic [CHUNK_W-1:0] chunk_index;
	logic               final_chunk;
	logic               relay_pick;
	logic               run_end;

	window_t model;
	window_t plan;
	beat_t   expected_beats[$];
	event_t  pending_events[$];
	event_t  next_event;
	beat_t   want_beat;
	int      errors = 0;
	bit      idle_on = 1'b0;
	int      in_gap = 0;
	int      stall_left = 0;
	int      quiet = 0;

	selective_repeat_sender_window dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.ack_seq     (ack_seq),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.seq_num     (seq_num),
		.chunk_index (chunk_index),
		.final_chunk (final_chunk),
		.relay_pick  (relay_pick),
		.run_end     (run_end)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// last chunk of the transfer; a zero total behaves like one
	function automatic logic chunk_is_last(input logic [CHUNK_W-1:0] idx,
			input logic [CHUNK_W-1:0] total);
		return (32'(idx) + 32'd1) >= 32'(total);
	endfunction

	// issue the next new chunk and remember it in its sequence slot
	task automatic issue_new(inout window_t w, output beat_t b);
		logic [CHUNK_W-1:0] idx;
		logic [SEQ_W-1:0]   seq;
		idx = w.issued;
		seq = SEQ_W'(idx % SEQ_MOD);
		b.kind = KIND_NEW;
		b.seq = seq;
		b.chunk = idx;
		b.fin = chunk_is_last(idx, w.total_pk);
		b.relay = idx[0];
		b.last = 1'b0;
		w.slot[seq] = idx;
		w.issued = idx + 1'b1;
		w.all_sent = b.fin;
	endtask

	// apply one event to a window; optionally queue the beats it causes
	task automatic advance(inout window_t w, input logic [CMD_W-1:0] cmd,
			input logic [SEQ_W-1:0] ack, input bit record);
		beat_t              beats[$];
		beat_t              b;
		logic [SEQ_W-1:0]   span;
		logic [SEQ_W-1:0]   off;
		logic [SEQ_W-1:0]   seq;
		logic [15:0]        need;
		logic [CHUNK_W-1:0] c;
		bit                 started;
		bit                 touched;
		if (w.finished)
			return;
		span = w.top - w.base;
		started = (w.issued != 0) || w.all_sent;
		touched = 1'b0;
		case (cmd)
			CMD_START: begin
				if (!started) begin
					for (int i = 0; i < WINDOW; i++) begin
						if (w.all_sent)
							break;
						w.top = SEQ_W'(i);
						issue_new(w, b);
						beats.push_back(b);
					end
				end
			end
			CMD_ACK: begin
				off = ack - w.base;
				if (started && off == 0) begin
					touched = 1'b1;
					if (w.all_sent) begin
						w.acked[0] = 1'b1;
					end else begin
						// slide while the new base is already acked
						for (int i = 0; i < WINDOW; i++) begin
							w.base = w.base + 1'b1;
							w.top = w.top + 1'b1;
							issue_new(w, b);
							beats.push_back(b);
							w.acked = w.acked >> 1;
							if (w.all_sent)
								break;
							if (!w.acked[0])
								break;
						end
					end
				end else if (started && off <= span) begin
					touched = 1'b1;
					w.acked = w.acked | (WINDOW'(1) << off);
				end
				// done once every position of the window is acked
				if (touched) begin
					span = w.top - w.base;
					need = (16'd2 << span) - 16'd1;
					if ((16'(w.acked) & need) == need) begin
						w.finished = 1'b1;
						b = '0;
						b.kind = KIND_DONE;
						beats.push_back(b);
					end
				end
			end
			CMD_TIMEOUT: begin
				if (started) begin
					for (int i = 0; i <= int'(span); i++) begin
						if (i < WINDOW && w.acked[i])
							continue;
						seq = w.base + SEQ_W'(i);
						c = w.slot[seq];
						b.kind = KIND_RETX;
						b.seq = seq;
						b.chunk = c;
						b.fin = chunk_is_last(c, w.total_pk);
						b.relay = c[0];
						b.last = 1'b0;
						beats.push_back(b);
					end
				end
			end
			default: begin
			end
		endcase
		// mark the final beat of this event
		if (beats.size() != 0) begin
			b = beats.pop_back();
			b.last = 1'b1;
			beats.push_back(b);
		end
		if (record)
			foreach (beats[k])
				expected_beats.push_back(beats[k]);
	endtask

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	// event driver with random gaps between beats
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_events.size() != 0) begin
				next_event = pending_events.pop_front();
				in_valid <= 1'b1;
				command <= next_event.cmd;
				ack_seq <= next_event.ack;
				if (idle_on && $urandom_range(0, 3) == 0)
					in_gap <= $urandom_range(1, 14);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 13);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// track register writes and accepted event beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				model.total_pk = cfg_wr_data;
			if (in_valid && !in_stall)
				advance(model, command, ack_seq, 1'b1);
		end
	end

	// compare each output beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, got kind %0d seq %0d chunk %0d",
					$time, kind, seq_num, chunk_index);
			end else begin
				want_beat = expected_beats.pop_front();
				check_field("kind", want_beat.kind, kind);
				check_field("seq_num", want_beat.seq, seq_num);
				check_field("chunk_index", want_beat.chunk, chunk_index);
				check_field("final_chunk", want_beat.fin, final_chunk);
				check_field("relay_pick", want_beat.relay, relay_pick);
				check_field("run_end", want_beat.last, run_end);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
				if (quiet >= QUIET_LIMIT) begin
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] ack);
		event_t ev;
		ev.cmd = cmd;
		ev.ack = ack;
		advance(plan, cmd, ack, 1'b0);
		pending_events.push_back(ev);
	endtask

	// mostly acks inside the window, some timeouts, a little noise
	task automatic queue_random(output bit counted);
		logic [CMD_W-1:0] cmd;
		logic [SEQ_W-1:0] ack;
		logic [SEQ_W-1:0] span;
		int               r;
		span = plan.top - plan.base;
		r = $urandom_range(0, 99);
		ack = SEQ_W'($urandom_range(0, SEQ_MOD - 1));
		if (r < 45) begin
			cmd = CMD_ACK;
			ack = plan.base;
		end else if (r < 75) begin
			cmd = CMD_ACK;
			ack = plan.base;
			if (span != 0)
				ack = plan.base + SEQ_W'($urandom_range(1, int'(span)));
		end else if (r < 88) begin
			cmd = CMD_TIMEOUT;
		end else if (r < 94) begin
			cmd = CMD_ACK;
			ack = plan.base + SEQ_W'($urandom_range(int'(span) + 1, SEQ_MOD - 1));
		end else if (r < 97) begin
			cmd = CMD_DATA;
		end else begin
			cmd = CMD_START;
		end
		counted = (cmd == CMD_TIMEOUT) ||
			(cmd == CMD_ACK && SEQ_W'(ack - plan.base) <= span);
		queue_cmd(cmd, ack);
	endtask

	task automatic write_total(input int unsigned v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CHUNK_W'(v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		plan.total_pk = CHUNK_W'(v);
	endtask

	// all events taken, all beats seen, then a short tail
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_events.size() != 0 || in_valid || expected_beats.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		int          rand_n;
		int          phase_len;
		bit          counted;
		bit          finishing;
		bit          wrote_zero;
		bit          wrote_one;
		logic [SEQ_W-1:0] span;
		model = '0;
		model.total_pk = 1;
		plan = model;
		rand_n = 0;
		finishing = 1'b0;
		wrote_zero = 1'b0;
		wrote_one = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: before start, start, resends, out-of-window acks, slides
		idle_on = 1'b1;
		write_total(65535);
		queue_cmd(CMD_DATA, 4'd5);
		queue_cmd(CMD_ACK, 4'd0);
		queue_cmd(CMD_TIMEOUT, 4'd15);
		queue_cmd(CMD_START, 4'd0);
		queue_cmd(CMD_START, 4'd9);
		queue_cmd(CMD_TIMEOUT, 4'd0);
		queue_cmd(CMD_ACK, 4'd3);
		queue_cmd(CMD_ACK, 4'd15);
		queue_cmd(CMD_ACK, 4'd8);
		queue_cmd(CMD_DATA, 4'd15);
		queue_cmd(CMD_ACK, 4'd0);
		queue_cmd(CMD_ACK, 4'd2);
		queue_cmd(CMD_ACK, 4'd1);
		queue_cmd(CMD_TIMEOUT, 4'd6);
		// fill the whole window above the base, then ack the base
		for (int i = 1; i < WINDOW; i++)
			queue_cmd(CMD_ACK, plan.base + SEQ_W'(i));
		queue_cmd(CMD_ACK, plan.base);
		queue_cmd(CMD_TIMEOUT, 4'd10);
		wait_idle();

		// random phases, with a register write before each until the final total is set
		while (!plan.finished && rand_n < 130) begin
			idle_on = (rand_n < 80) && ($urandom_range(0, 3) != 0);
			span = plan.top - plan.base;
			if (plan.all_sent && !wrote_zero) begin
				write_total(0);
				wrote_zero = 1'b1;
				queue_cmd(CMD_TIMEOUT, SEQ_W'($urandom_range(0, SEQ_MOD - 1)));
				queue_cmd(CMD_ACK, plan.base + span + 1'b1);
				queue_cmd(CMD_TIMEOUT, SEQ_W'($urandom_range(0, SEQ_MOD - 1)));
				rand_n += 2;
			end else if (plan.all_sent && !wrote_one) begin
				write_total(1);
				wrote_one = 1'b1;
				// base acked twice after the last chunk
				queue_cmd(CMD_ACK, plan.base);
				queue_cmd(CMD_ACK, plan.base);
				queue_cmd(CMD_TIMEOUT, SEQ_W'($urandom_range(0, SEQ_MOD - 1)));
				rand_n += 3;
			end else begin
				if (!finishing && rand_n >= 60) begin
					write_total(int'(plan.issued) + $urandom_range(2, 6));
					finishing = 1'b1;
				end else if (!finishing) begin
					write_total($urandom_range(int'(plan.issued) + 40, 65535));
				end
				phase_len = $urandom_range(6, 16);
				for (int i = 0; i < phase_len && !plan.finished; i++) begin
					queue_random(counted);
					rand_n += counted;
				end
			end
			wait_idle();
		end

		// events after done must be ignored
		idle_on = 1'b0;
		queue_cmd(CMD_START, 4'd0);
		queue_cmd(CMD_ACK, plan.base);
		queue_cmd(CMD_TIMEOUT, 4'd15);
		queue_cmd(CMD_DATA, 4'd10);
		wait_idle();
		repeat (4 * TAIL_CYCLES) @(posedge clk);

		if (expected_beats.size() != 0) begin
			errors++;
			$display("%0t: beats missing, expected %0d more, got 0",
				$time, expected_beats.size());
		end
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/srsw_pkg.sv
sv/selective_repeat_sender_window.sv
test/selective_repeat_sender_window_test.sv
